FILE: design/weighted_round_robin_class_picker_top_macros.svh
// Assertion macros for the class picker.
`ifndef WEIGHTED_ROUND_ROBIN_CLASS_PICKER_TOP_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_CLASS_PICKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define WRRCP_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wrrcp assertion failed");
`define WRRCP_ASSERT(lbl, prop) \
  `WRRCP_ASSERT_CR(lbl, clk_i, rst_ni, prop)
`else
`define WRRCP_ASSERT_CR(lbl, clk, rstn, prop)
`define WRRCP_ASSERT(lbl, prop)
`endif

`endif

FILE: design/wrrcp_pkg.sv
`default_nettype none

package wrrcp_pkg;

  localparam int unsigned NumClassesDef = 6;
  localparam int unsigned NumWeightRegs = 6;
  localparam int unsigned BusyW         = 6;
  localparam int unsigned ClassW        = 3;
  localparam int unsigned WeightW       = 8;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [WeightW-1:0] WeightReset = 8'd1;

  typedef logic [NumWeightRegs-1:0][WeightW-1:0] weight_arr_t;

  // scheduler state kept between requests
  typedef struct packed {
    logic [ClassW-1:0]  cls;
    logic [WeightW-1:0] credit;
  } sched_state_t;

  // outcome of one scan
  typedef struct packed {
    logic               grant;
    logic [ClassW-1:0]  cls;
    logic [WeightW-1:0] credit;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: design/wrrcp_if.sv
`default_nettype none

interface wrrcp_in_if;
  import wrrcp_pkg::*;
  logic             valid;
  logic             ready;
  logic [BusyW-1:0] busy_mask;
  logic             slots_full;

  modport source (output valid, output busy_mask, output slots_full, input ready);
  modport sink   (input valid, input busy_mask, input slots_full, output ready);
endinterface

interface wrrcp_out_if;
  import wrrcp_pkg::*;
  logic              valid;
  logic              ready;
  logic              grant_valid;
  logic [ClassW-1:0] grant_class;

  modport source (output valid, output grant_valid, output grant_class, input ready);
  modport sink   (input valid, input grant_valid, input grant_class, output ready);
endinterface

`default_nettype wire

FILE: design/weighted_round_robin_class_picker_top.sv
// Flow: a request word is captured in the input register, goes through the
//   scan and is held in the result register until the sink takes its grant.
// Throughput: one request word per cycle unless the sink stalls; the class scan
//   and credit update sit in the single combinational stage between the two registers.
// Reset: asynchronous, active low; both stages empty, class 0, credit 1,
//   all class weights 1.
`default_nettype none

`include "weighted_round_robin_class_picker_top_macros.svh"

module weighted_round_robin_class_picker_top
  import wrrcp_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = NumClassesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  wrrcp_in_if.sink                in_ch,
  wrrcp_out_if.source             out_ch,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WeightW-1:0] cfg_data_i
);

  weight_arr_t weights;

  logic             in_vld_q;
  logic [BusyW-1:0] busy_q;
  logic             full_q;

  logic              out_vld_q;
  logic              gnt_vld_q;
  logic [ClassW-1:0] gnt_cls_q;

  sched_state_t state_q;
  scan_res_t    res;

  logic adv;
  logic in_rdy;

  wrrcp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .weights_o  (weights)
  );

  wrrcp_scan #(
    .NumClasses (NUM_CLASSES)
  ) u_scan (
    .busy_i    (busy_q),
    .full_i    (full_q),
    .state_i   (state_q),
    .weights_i (weights),
    .res_o     (res)
  );

  assign adv    = !out_vld_q || out_ch.ready;
  assign in_rdy = !in_vld_q || adv;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_ch.valid) begin
      busy_q <= in_ch.busy_mask;
      full_q <= in_ch.slots_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      gnt_vld_q <= res.grant;
      gnt_cls_q <= res.cls;
    end
  end

  // state moves only on a grant; a refused request leaves it alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cls    <= '0;
      state_q.credit <= WeightReset;
    end else if (adv && in_vld_q && res.grant) begin
      state_q.cls    <= res.cls;
      state_q.credit <= res.credit;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.grant_valid = gnt_vld_q;
  assign out_ch.grant_class = gnt_cls_q;

  `WRRCP_ASSERT(a_cls_in_range, state_q.cls < ClassW'(NUM_CLASSES))
  `WRRCP_ASSERT(a_idle_cls_zero, (out_vld_q && !gnt_vld_q) |-> (gnt_cls_q == '0))
  `WRRCP_ASSERT(a_grant_tracks_state, (adv && in_vld_q && res.grant) |=> (out_vld_q && gnt_vld_q && gnt_cls_q == state_q.cls))
  `WRRCP_ASSERT(a_refused_keeps_state, (adv && in_vld_q && !res.grant) |=> ($stable(state_q) && !gnt_vld_q))
  `WRRCP_ASSERT(a_blocked_no_take, (in_vld_q && !adv) |-> !in_rdy)

endmodule

`default_nettype wire

FILE: design/wrrcp_cfg_regs.sv
`default_nettype none

module wrrcp_cfg_regs
  import wrrcp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WeightW-1:0] cfg_data_i,
  output weight_arr_t             weights_o
);

  weight_arr_t weight_q;

  // indexes past the last weight register fall through and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWeightRegs; i++) begin
        weight_q[i] <= WeightReset;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumWeightRegs; i++) begin
        if (cfg_idx_i == CfgIdxW'(i)) begin
          weight_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign weights_o = weight_q;

endmodule

`default_nettype wire

FILE: design/wrrcp_scan.sv
`default_nettype none

module wrrcp_scan
  import wrrcp_pkg::*;
#(
  parameter int unsigned NumClasses = NumClassesDef
) (
  input  wire logic [BusyW-1:0] busy_i,
  input  wire logic             full_i,
  input  wire sched_state_t     state_i,
  input  wire weight_arr_t      weights_i,
  output scan_res_t             res_o
);

  localparam logic [ClassW-1:0] LastCls = ClassW'(NumClasses - 1);
  localparam logic [ClassW:0]   NumW    = (ClassW + 1)'(NumClasses);

  logic [ClassW-1:0]  base;
  logic [ClassW-1:0]  start;
  logic [WeightW-1:0] cred_start;
  logic [ClassW:0]    sum;
  logic [ClassW:0]    cand;
  logic               found;
  logic [ClassW-1:0]  pick;

  always_comb begin
    base = (state_i.cls > LastCls) ? '0 : state_i.cls;
    // spent credit hands the turn on before the scan starts
    if (state_i.credit == '0) begin
      start      = (base == LastCls) ? '0 : base + ClassW'(1);
      cred_start = weights_i[start];
    end else begin
      start      = base;
      cred_start = state_i.credit;
    end
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    sum   = '0;
    cand  = '0;
    for (int k = 0; k < NumClasses; k++) begin
      sum  = {1'b0, start} + (ClassW + 1)'(k);
      cand = (sum >= NumW) ? sum - NumW : sum;
      if (!found && busy_i[cand[ClassW-1:0]]) begin
        found = 1'b1;
        pick  = cand[ClassW-1:0];
      end
    end
  end

  always_comb begin
    res_o.grant  = found && !full_i;
    res_o.cls    = res_o.grant ? pick : '0;
    res_o.credit = ((pick == start) ? cred_start : weights_i[pick]) - WeightW'(1);
  end

endmodule

`default_nettype wire

FILE: tb/weighted_round_robin_class_picker_top_tb.sv
`timescale 1ns / 100ps

module weighted_round_robin_class_picker_top_tb;
  import wrrcp_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned DrainCycles = 4;
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = CfgIdxW'(NumWeightRegs);
  localparam logic [CfgIdxW-1:0] LastCfgIdx = '1;

  typedef struct packed {
    logic              gv;
    logic [ClassW-1:0] gc;
  } grant_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WeightW-1:0] cfg_data;

  wrrcp_in_if  in_ch ();
  wrrcp_out_if out_ch ();

  weighted_round_robin_class_picker_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: turn holder, credit left, weights as programmed
  logic [ClassW-1:0]  sched_cls;
  logic [WeightW-1:0] sched_credit;
  logic [WeightW-1:0] class_weight [NumWeightRegs];

  grant_word_t expected_grants [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit source_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int sink_hold = 0;

  function automatic logic [ClassW-1:0] step_class(logic [ClassW-1:0] c);
    return (c == ClassW'(NumClassesDef - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic grant_word_t pick_class(logic [BusyW-1:0] busy, logic full);
    grant_word_t        g;
    logic [ClassW-1:0]  c;
    logic [WeightW-1:0] cr;
    g = '0;
    if (full || busy == '0) return g;
    c = (sched_cls >= ClassW'(NumClassesDef)) ? '0 : sched_cls;
    cr = sched_credit;
    if (cr == '0) begin
      c = step_class(c);
      cr = class_weight[c];
    end
    for (int i = 0; i < NumClassesDef; i++) begin
      cr = cr - 1'b1;  // wraps past zero
      if (busy[c]) begin
        sched_cls = c;
        sched_credit = cr;
        g.gv = 1'b1;
        g.gc = c;
        return g;
      end
      c = step_class(c);
      cr = class_weight[c];
    end
    return g;
  endfunction

  // mostly zero, some short, a few long
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BusyW-1:0] rand_busy();
    int r;
    logic [BusyW-1:0] m;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        m = '0;
      end
      1: begin
        m = '1;
      end
      2, 3, 4: begin
        m = BusyW'(1) << $urandom_range(0, BusyW - 1);
      end
      5, 6: begin
        m = (BusyW'(1) << $urandom_range(0, BusyW - 1)) |
            (BusyW'(1) << $urandom_range(0, BusyW - 1));
      end
      default: begin
        m = BusyW'($urandom);
      end
    endcase
    return m;
  endfunction

  task automatic send_request(input logic [BusyW-1:0] busy, input logic full);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.busy_mask <= busy;
    in_ch.slots_full <= full;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_grants.push_back(pick_class(busy, full));
    gap = source_gaps ? stall_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // writes all weights while idle; optionally also hits the unused indexes
  task automatic set_weights(input weight_arr_t w, input bit stray);
    wait_drain();
    for (int i = 0; i < NumWeightRegs; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      cfg_data <= w[i];
      class_weight[i] = w[i];
      @(posedge clk_i);
    end
    if (stray) begin
      for (int i = FirstUnusedIdx; i <= LastCfgIdx; i++) begin
        cfg_idx <= CfgIdxW'(i);
        cfg_data <= WeightW'($urandom);
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_no_grant_cases();
    send_request('1, 1'b1);
    send_request('0, 1'b1);
    send_request('0, 1'b0);
    send_request(BusyW'(1), 1'b1);
  endtask

  task automatic test_each_class();
    for (int i = 0; i < BusyW; i++) send_request(BusyW'(1) << i, 1'b0);
    send_request('1, 1'b0);
    send_request('1, 1'b0);
  endtask

  // max weight, zero weight (credit wraps) and writes to unused indexes
  task automatic test_weight_extremes();
    weight_arr_t w;
    w = '{default: WeightReset};
    w[0] = 8'd2;
    w[1] = 8'd0;
    w[2] = 8'd255;
    set_weights(w, 1'b1);
    repeat (4) send_request('1, 1'b0);
    send_request(BusyW'(4), 1'b0);
    send_request(BusyW'(4), 1'b0);
    send_request(BusyW'(1), 1'b0);
    send_request('1, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    weight_arr_t w;
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < NumWeightRegs; i++) begin
        case (phase)
          0: w[i] = WeightReset;
          1: w[i] = 8'd255;
          2: w[i] = WeightW'($urandom_range(1, 4));
          3: w[i] = WeightW'($urandom_range(1, 255));
          4: begin
            case ($urandom_range(0, 3))
              0: w[i] = 8'd1;
              1: w[i] = 8'd255;
              2: w[i] = 8'd0;
              default: w[i] = WeightW'($urandom_range(1, 255));
            endcase
          end
          default: w[i] = WeightW'($urandom_range(1, 3));
        endcase
      end
      set_weights(w, phase == 3);
      source_gaps = (phase != 1) && (phase != 3);
      sink_stalls = (phase != 1) && (phase != 4);
      repeat (PhaseItems) send_request(rand_busy(), $urandom_range(0, 9) == 0);
    end
    wait_drain();
  endtask

  // sink holds off while requests keep coming, then the source waits it out
  task automatic test_output_backpressure();
    source_gaps = 1'b0;
    sink_stalls = 1'b1;
    sink_hold = 300;
    repeat (40) send_request(rand_busy(), $urandom_range(0, 9) == 0);
    wait_drain();
  endtask

  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else begin
        n = sink_stalls ? stall_len() : 0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          sink_hold = n - 1;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    grant_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_grants.size() == 0) begin
        $error("grant word with no request pending");
        fail_count++;
      end else begin
        want = expected_grants.pop_front();
        if (out_ch.grant_valid !== want.gv) begin
          $error("grant_valid: expected %0d, got %0d", want.gv, out_ch.grant_valid);
          fail_count++;
        end
        if (out_ch.grant_class !== want.gc) begin
          $error("grant_class: expected %0d, got %0d", want.gc, out_ch.grant_class);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("weighted_round_robin_class_picker_top: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.busy_mask = '0;
    in_ch.slots_full = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    for (int i = 0; i < NumWeightRegs; i++) class_weight[i] = WeightReset;
    sched_cls = '0;
    sched_credit = WeightReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_grant_cases();
    test_each_class();
    test_weight_extremes();
    test_random_traffic();
    test_output_backpressure();

    if (fail_count == 0) begin
      $display("weighted_round_robin_class_picker_top: match");
    end else begin
      $display("weighted_round_robin_class_picker_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/wrrcp_pkg.sv
design/wrrcp_if.sv
design/wrrcp_cfg_regs.sv
design/wrrcp_scan.sv
design/weighted_round_robin_class_picker_top.sv
tb/weighted_round_robin_class_picker_top_tb.sv
